// ----- rtl/s2l_pkg.sv -----
// shared types, constants and calendar functions for the solar to lunar date converter
// no dependencies; the other rtl files that use this package refer to it by scoped names
`default_nettype none

package s2l_pkg;

  localparam int TABLE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(TABLE_BYTES);
  // wide enough for the largest table address a seven-bit year can produce
  localparam int CALC_W      = 11;

  localparam int YEAR_W  = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;
  localparam int NY_W    = 8;
  localparam int LEN_W   = 5;
  localparam int SLOT_W  = 4;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  localparam logic [LEN_W-1:0]   LEN_SMALL      = 5'h1d;
  localparam logic [LEN_W-1:0]   LEN_BIG        = 5'h1e;
  localparam logic [NY_W-1:0]    JAN_DAYS       = 8'h1f;
  localparam logic [YEAR_W-1:0]  YEAR_LAST      = 7'h63;
  localparam logic [CALC_W-1:0]  YEAR_BIAS      = 11'd99;
  localparam logic [CALC_W-1:0]  BYTES_PER_YEAR = 11'd3;
  localparam logic [MONTH_W-1:0] MONTH_FIRST    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST     = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [SLOT_W-1:0]  SLOT_FIRST     = 4'd1;
  localparam logic [SLOT_W-1:0]  SLOT_LAST      = 4'd12;
  localparam logic [SLOT_W-1:0]  SLOT_EXTRA     = 4'd13;
  localparam logic [1:0]         NY_IN_JAN      = 2'd1;

  typedef struct packed {
    logic               mode;
    logic [9:0]         table_index;
    logic [7:0]         table_byte;
    logic [YEAR_W-1:0]  solar_year;
    logic [MONTH_W-1:0] solar_month;
    logic [DAY_W-1:0]   solar_day;
  } in_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  lunar_year;
    logic [MONTH_W-1:0] lunar_month;
    logic [DAY_W-1:0]   lunar_day;
    logic               century_back;
  } out_res_t;

  // month walk state
  typedef struct packed {
    logic               fwd;
    logic [DOY_W-1:0]   cnt;
    logic [SLOT_W-1:0]  slot;
    logic [MONTH_W-1:0] lm;
    logic               in_leap;
  } walk_t;

  typedef struct packed {
    logic             done;
    logic [DAY_W-1:0] day;
    walk_t            next;
  } step_t;

  // days before the first of a (clamped) gregorian month, common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // length of lunar month slot, big/small bits spread over the three year bytes
  function automatic logic [LEN_W-1:0] month_len(input logic [SLOT_W-1:0] slot,
                                                 input logic [7:0] b0,
                                                 input logic [7:0] b1,
                                                 input logic [7:0] b2);
    logic big;
    case (slot)
      4'd1:    big = b0[3];
      4'd2:    big = b0[2];
      4'd3:    big = b0[1];
      4'd4:    big = b0[0];
      4'd5:    big = b1[7];
      4'd6:    big = b1[6];
      4'd7:    big = b1[5];
      4'd8:    big = b1[4];
      4'd9:    big = b1[3];
      4'd10:   big = b1[2];
      4'd11:   big = b1[1];
      4'd12:   big = b1[0];
      4'd13:   big = b2[7];
      default: big = 1'b0;
    endcase
    return big ? LEN_BIG : LEN_SMALL;
  endfunction

  // day of the solar year on which lunar new year falls, zero based
  function automatic logic [NY_W-1:0] ny_offset(input logic [7:0] b2);
    logic [NY_W-1:0] nd;
    nd = {3'b000, b2[4:0]};
    if (b2[6:5] == NY_IN_JAN) begin
      return nd - 8'd1;
    end
    return nd + JAN_DAYS - 8'd1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/s2l_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module s2l_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/s2l_month_step.sv -----
// one step of the lunar month walk: length lookup, subtract and leap bookkeeping
// depends on s2l_pkg
`default_nettype none

module s2l_month_step (
  input  wire s2l_pkg::walk_t cur,
  input  wire logic [7:0]     byte0,
  input  wire logic [7:0]     byte1,
  input  wire logic [7:0]     byte2,
  output s2l_pkg::step_t      step
);

  logic [s2l_pkg::LEN_W-1:0]   len;
  logic [s2l_pkg::DOY_W-1:0]   len_x;
  logic [s2l_pkg::MONTH_W-1:0] leap;
  logic [s2l_pkg::MONTH_W-1:0] lm_dn;

  always_comb begin
    len   = s2l_pkg::month_len(cur.slot, byte0, byte1, byte2);
    len_x = {{(s2l_pkg::DOY_W - s2l_pkg::LEN_W){1'b0}}, len};
    leap  = byte0[7:4];
    lm_dn = cur.in_leap ? cur.lm : cur.lm - 1'b1;

    step.next = cur;
    step.done = 1'b0;
    step.day  = '0;

    if (cur.fwd) begin
      if (cur.cnt >= len_x) begin
        step.next.cnt  = cur.cnt - len_x;
        step.next.slot = cur.slot + 1'b1;
        if (cur.lm == leap) begin
          step.next.in_leap = !cur.in_leap;
          // leaving the leap copy moves on to the next month number
          if (cur.in_leap) begin
            step.next.lm = cur.lm + 1'b1;
          end
        end else begin
          step.next.lm = cur.lm + 1'b1;
        end
      end else begin
        step.done = 1'b1;
        step.day  = cur.cnt[s2l_pkg::DAY_W-1:0] + 1'b1;
      end
    end else begin
      if (cur.cnt > len_x) begin
        step.next.cnt  = cur.cnt - len_x;
        step.next.slot = cur.slot - 1'b1;
        step.next.lm   = lm_dn;
        if (lm_dn == leap) begin
          step.next.in_leap = !cur.in_leap;
        end
      end else begin
        step.done = 1'b1;
        step.day  = len - cur.cnt[s2l_pkg::DAY_W-1:0] + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/solar_to_lunar_date_converter.sv -----
// top level of the gregorian to chinese lunar date converter
// depends on s2l_pkg, s2l_ram and s2l_month_step
`default_nettype none

// The block keeps a byte-wide lunar year table in one on-chip memory of
// s2l_pkg::TABLE_BYTES bytes, three bytes per lunar year at base address
// (year + 99) * 3. A request with mode 0 writes one table byte and gives
// no result. A request with mode 1 converts a Gregorian date with a
// seven-bit year counted from 2000 (0 to 127) and gives one result: lunar
// year, month (a leap month repeats its number), day and a flag that is
// set when year 0 stepped back to year 99. A conversion is accepted, reads
// the new year byte, fetches the three bytes of the lunar year in use,
// walks the lunar months until the date falls inside one, and then hands
// the result over once the output register is free. The single read port
// of the table memory sets the fetch phase and the month walk moves one
// month per cycle. The table must be written before any entry is read;
// there is no clearing pass. A result waiting in the output register does
// not block the next request.

module solar_to_lunar_date_converter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire s2l_pkg::in_req_t    in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output s2l_pkg::out_res_t        out_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NYEAR = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // fetch phase positions
  localparam logic [1:0] FETCH_B0 = 2'd1;
  localparam logic [1:0] FETCH_B1 = 2'd2;
  localparam logic [1:0] FETCH_B2 = 2'd3;

  logic [2:0]                     state_r,     state_nxt;
  logic [s2l_pkg::YEAR_W-1:0]     year_r,      year_nxt;
  logic [s2l_pkg::DOY_W-1:0]      doy_r,       doy_nxt;
  logic [s2l_pkg::CALC_W-1:0]     base_r,      base_nxt;
  logic [1:0]                     idx_r,       idx_nxt;
  logic [7:0]                     b0_r,        b0_nxt;
  logic [7:0]                     b1_r,        b1_nxt;
  logic [7:0]                     b2_r,        b2_nxt;
  logic                           back_r,      back_nxt;
  logic                           oob_r,       oob_nxt;
  s2l_pkg::walk_t                 walk_r,      walk_nxt;
  s2l_pkg::out_res_t              res_r,       res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  s2l_pkg::out_res_t              out_data_r,  out_data_nxt;

  logic                           in_acc;
  logic                           ram_we;
  logic [s2l_pkg::CALC_W-1:0]     year_ext;
  logic [s2l_pkg::CALC_W-1:0]     in_base;
  logic [s2l_pkg::CALC_W-1:0]     rd_calc;
  logic [7:0]                     ram_q;
  logic [7:0]                     rd_byte;
  logic [s2l_pkg::MONTH_W-1:0]    month_c;
  logic [s2l_pkg::DAY_W-1:0]      day_c;
  logic [s2l_pkg::DOY_W-1:0]      doy_calc;
  logic [s2l_pkg::DOY_W-1:0]      ny9;
  logic                           fwd;
  logic                           out_free;
  s2l_pkg::step_t                 step;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // table writes land straight in memory when the request is taken
  assign ram_we = in_acc && (in_data.mode == s2l_pkg::MODE_WRITE) &&
                  ({1'b0, in_data.table_index} < s2l_pkg::CALC_W'(s2l_pkg::TABLE_BYTES));

  // table base of the requested year, times three by shift and add
  assign year_ext = s2l_pkg::CALC_W'(in_data.solar_year) + s2l_pkg::YEAR_BIAS;
  assign in_base  = (year_ext << 1) + year_ext;

  // read address: new year byte while idle, then the three bytes of the chosen year
  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_calc = in_base + 11'd2;
      S_FETCH: rd_calc = base_r + s2l_pkg::CALC_W'(idx_r);
      default: rd_calc = base_r;
    endcase
  end

  // addresses beyond the table read as zero
  assign oob_nxt = (rd_calc >= s2l_pkg::CALC_W'(s2l_pkg::TABLE_BYTES));
  assign rd_byte = oob_r ? 8'h00 : ram_q;

  s2l_ram #(
    .WIDTH (8),
    .DEPTH (s2l_pkg::TABLE_BYTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.table_index[s2l_pkg::ADDR_W-1:0]),
    .wdata (in_data.table_byte),
    .raddr (rd_calc[s2l_pkg::ADDR_W-1:0]),
    .rdata (ram_q)
  );

  s2l_month_step u_step (
    .cur   (walk_r),
    .byte0 (b0_r),
    .byte1 (b1_r),
    .byte2 (b2_r),
    .step  (step)
  );

  // day of the solar year, with out of range month and day pulled into range
  always_comb begin
    month_c = in_data.solar_month;
    if (month_c < s2l_pkg::MONTH_FIRST) begin
      month_c = s2l_pkg::MONTH_FIRST;
    end
    if (month_c > s2l_pkg::MONTH_LAST) begin
      month_c = s2l_pkg::MONTH_LAST;
    end
    day_c = (in_data.solar_day == '0) ? 5'd1 : in_data.solar_day;
    doy_calc = s2l_pkg::cum_days(month_c) + s2l_pkg::DOY_W'(day_c) - 9'd1;
    // every fourth year of the century is a leap year
    if ((month_c > s2l_pkg::MONTH_FEB) && (in_data.solar_year[1:0] == 2'b00)) begin
      doy_calc = doy_calc + 9'd1;
    end
  end

  // before or after this year's lunar new year
  assign ny9 = s2l_pkg::DOY_W'(s2l_pkg::ny_offset(rd_byte));
  assign fwd = (doy_r >= ny9);

  always_comb begin
    state_nxt     = state_r;
    year_nxt      = year_r;
    doy_nxt       = doy_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    back_nxt      = back_r;
    walk_nxt      = walk_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.mode == s2l_pkg::MODE_CONVERT)) begin
          year_nxt  = in_data.solar_year;
          doy_nxt   = doy_calc;
          base_nxt  = in_base;
          back_nxt  = 1'b0;
          state_nxt = S_NYEAR;
        end
      end

      S_NYEAR: begin
        // new year byte is on the read data now
        walk_nxt.fwd     = fwd;
        walk_nxt.in_leap = 1'b0;
        if (fwd) begin
          walk_nxt.cnt = doy_r - ny9;
        end else begin
          // date lies before new year: walk back through the previous lunar year
          walk_nxt.cnt = ny9 - doy_r;
          base_nxt     = base_r - s2l_pkg::BYTES_PER_YEAR;
          if (year_r == '0) begin
            year_nxt = s2l_pkg::YEAR_LAST;
            back_nxt = 1'b1;
          end else begin
            year_nxt = year_r - 1'b1;
          end
        end
        idx_nxt   = '0;
        state_nxt = S_FETCH;
      end

      S_FETCH: begin
        idx_nxt = idx_r + 1'b1;
        case (idx_r)
          FETCH_B0: b0_nxt = rd_byte;
          FETCH_B1: b1_nxt = rd_byte;
          FETCH_B2: b2_nxt = rd_byte;
          default: ;
        endcase
        if (idx_r == FETCH_B2) begin
          if (walk_r.fwd) begin
            walk_nxt.lm   = s2l_pkg::MONTH_FIRST;
            walk_nxt.slot = s2l_pkg::SLOT_FIRST;
          end else begin
            // backward walk starts at the last month slot of the year
            walk_nxt.lm   = s2l_pkg::MONTH_LAST;
            walk_nxt.slot = (b0_r[7:4] == '0) ? s2l_pkg::SLOT_LAST : s2l_pkg::SLOT_EXTRA;
          end
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (step.done) begin
          res_nxt.lunar_year   = year_r;
          res_nxt.lunar_month  = walk_r.lm;
          res_nxt.lunar_day    = step.day;
          res_nxt.century_back = back_r;
          state_nxt            = S_DONE;
        end else begin
          walk_nxt = step.next;
        end
      end

      S_DONE: begin
        // hand over once the output register is free or being emptied
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    year_r     <= year_nxt;
    doy_r      <= doy_nxt;
    base_r     <= base_nxt;
    idx_r      <= idx_nxt;
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    back_r     <= back_nxt;
    oob_r      <= oob_nxt;
    walk_r     <= walk_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for solar_to_lunar_date_converter: loads the lunar year table,
// sends directed and random conversion requests and checks every result in order
// depends on s2l_pkg and the rtl of the converter

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import s2l_pkg::*;

  // new year month code for february (anything other than january counts as february)
  localparam logic [1:0] NY_IN_FEB = 2'd2;
  // table rows touched by any seven-bit year: previous year of year 0 up to year 127
  localparam int FIRST_ROW_BYTE = 98 * 3;
  localparam int LAST_ROW_BYTE  = (127 + 99) * 3 + 2;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  // testbench copy of the lunar year table
  logic [7:0] lunar_tab [0:TABLE_BYTES-1];
  // days before the first of each month in a common year
  int days_before [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  in_req_t  req_queue[$];
  out_res_t lunar_dates_due[$];

  int   total_reqs   = 0;
  int   taken_cnt    = 0;
  int   results_seen = 0;
  int   err_cnt      = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  logic hold_off     = 1'b0;
  logic idle_ok;

  solar_to_lunar_date_converter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // idling bursts allowed except in every fourth window and in the last stretch
  assign idle_ok = (taken_cnt + 200 < total_reqs) && ((taken_cnt / 128) % 4 != 3);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // table read, zero beyond the end of the table
  function automatic logic [7:0] tab_byte(input int a);
    return (a >= 0 && a < TABLE_BYTES) ? lunar_tab[a] : 8'h00;
  endfunction

  // length of lunar month slot in the year whose row starts at row
  function automatic int moon_days(input int slot, input int row);
    logic [7:0] b;
    logic       big;
    big = 1'b0;
    if (slot >= 1 && slot <= 4) begin
      b   = tab_byte(row);
      big = b[4 - slot];
    end else if (slot >= 5 && slot <= 12) begin
      b   = tab_byte(row + 1);
      big = b[12 - slot];
    end else if (slot == 13) begin
      b   = tab_byte(row + 2);
      big = b[7];
    end
    return big ? LEN_BIG : LEN_SMALL;
  endfunction

  // applies one request to the table copy; returns 1 with the lunar date for a conversion
  function automatic bit predict_lunar_date(input in_req_t rq, output out_res_t res);
    int         yr, mo, dy, row, nd, ny_off, doy, leap, slot, len, lm, rem;
    bit         back, in_leap;
    logic [7:0] nyb;
    res     = '0;
    back    = 1'b0;
    in_leap = 1'b0;
    if (rq.mode == MODE_WRITE) begin
      lunar_tab[rq.table_index] = rq.table_byte;
      return 1'b0;
    end
    yr = rq.solar_year;
    mo = rq.solar_month;
    dy = rq.solar_day;
    // out of range month and day are clamped
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    if (dy < 1) dy = 1;
    row = (yr + 99) * 3;
    nyb = tab_byte(row + 2);
    nd  = nyb[4:0];
    if (nyb[6:5] == NY_IN_JAN) ny_off = (nd - 1) & 8'hff;
    else ny_off = (nd + 31 - 1) & 8'hff;
    doy = days_before[mo - 1] + dy - 1;
    if (mo > 2 && yr % 4 == 0) doy++;
    if (doy >= ny_off) begin
      // forward walk from this year's new year
      doy  -= ny_off;
      lm    = 1;
      slot  = 1;
      len   = moon_days(slot, row);
      leap  = tab_byte(row) >> 4;
      while (doy >= len) begin
        doy -= len;
        slot++;
        if (lm == leap) begin
          in_leap = !in_leap;
          if (!in_leap) lm++;
        end else begin
          lm++;
        end
        len = moon_days(slot, row);
      end
      res.lunar_day = doy + 1;
    end else begin
      // backward walk from the previous lunar year's last month
      rem = ny_off - doy;
      if (yr == 0) begin
        yr   = 99;
        back = 1'b1;
      end else begin
        yr--;
      end
      row -= 3;
      lm   = 12;
      leap = tab_byte(row) >> 4;
      slot = (leap == 0) ? 12 : 13;
      len  = moon_days(slot, row);
      while (rem > len) begin
        rem -= len;
        slot--;
        if (!in_leap) lm--;
        if (lm == leap) in_leap = !in_leap;
        len = moon_days(slot, row);
      end
      res.lunar_day = len - rem + 1;
    end
    res.lunar_year   = yr[6:0];
    res.lunar_month  = lm[3:0];
    res.century_back = back;
    return 1'b1;
  endfunction

  // table write request, date fields carry noise
  function automatic void put_write(input int addr, input int val);
    in_req_t rq;
    rq             = in_req_t'({$urandom, $urandom});
    rq.mode        = MODE_WRITE;
    rq.table_index = addr[9:0];
    rq.table_byte  = val[7:0];
    req_queue.push_back(rq);
  endfunction

  // conversion request, table fields carry noise
  function automatic void put_date(input int y, input int m, input int d);
    in_req_t rq;
    rq             = in_req_t'({$urandom, $urandom});
    rq.mode        = MODE_CONVERT;
    rq.solar_year  = y[6:0];
    rq.solar_month = m[3:0];
    rq.solar_day   = d[4:0];
    req_queue.push_back(rq);
  endfunction

  // request driver: predicts on acceptance, holds a stalled request, random gaps between requests
  always @(posedge clk) begin
    out_res_t due_res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_lunar_date(in_data, due_res)) lunar_dates_due.push_back(due_res);
        taken_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          in_data  <= req_queue.pop_front();
          in_valid <= 1'b1;
          if (idle_ok && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks field by field against the oldest expected date, random stall bursts
  always @(posedge clk) begin
    out_res_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (lunar_dates_due.size() == 0) begin
          note_mismatch("result with no conversion outstanding");
        end else begin
          exp_res = lunar_dates_due.pop_front();
          if (out_data.lunar_year !== exp_res.lunar_year)
            note_mismatch($sformatf("lunar_year got %0d expected %0d",
                                    out_data.lunar_year, exp_res.lunar_year));
          if (out_data.lunar_month !== exp_res.lunar_month)
            note_mismatch($sformatf("lunar_month got %0d expected %0d",
                                    out_data.lunar_month, exp_res.lunar_month));
          if (out_data.lunar_day !== exp_res.lunar_day)
            note_mismatch($sformatf("lunar_day got %0d expected %0d",
                                    out_data.lunar_day, exp_res.lunar_day));
          if (out_data.century_back !== exp_res.century_back)
            note_mismatch($sformatf("century_back got %0d expected %0d",
                                    out_data.century_back, exp_res.century_back));
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_ok && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // long output hold-off so the converter backs up and stalls its input
  initial begin
    while (results_seen < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // stimulus and end of run
  initial begin
    int k, y, m, d;
    // every table row that a seven-bit year can reach is loaded first
    for (k = FIRST_ROW_BYTE; k <= LAST_ROW_BYTE; k++) put_write(k, $urandom_range(0, 255));

    // table corners
    put_write(1023, 8'hff);
    put_write(0, 8'h00);
    // first day of the century steps back, last year, year above 99, clamped fields
    put_date(0, 1, 1);
    put_date(99, 12, 31);
    put_date(127, 15, 31);
    put_date(0, 0, 0);
    put_date(4, 13, 0);
    put_date(4, 3, 1);
    // new year on the first of january, so the first day starts the lunar year
    put_write((10 + 99) * 3 + 2, {1'b1, NY_IN_JAN, 5'd1});
    put_date(10, 1, 1);
    put_date(10, 12, 31);
    // new year day zero in january wraps the offset round to 255
    put_write((10 + 99) * 3 + 2, {1'b0, NY_IN_JAN, 5'd0});
    put_date(10, 1, 1);
    put_date(10, 12, 31);
    // leap fourth month, all months big, new year late in february
    put_write((20 + 99) * 3, 8'h4f);
    put_write((20 + 99) * 3 + 1, 8'hff);
    put_write((20 + 99) * 3 + 2, {1'b1, NY_IN_FEB, 5'd31});
    put_date(20, 12, 31);
    put_date(20, 8, 15);
    // previous year with a leap twelfth month, walked back through the thirteenth slot
    put_write((19 + 99) * 3, 8'hc0);
    put_date(20, 1, 1);
    put_date(20, 3, 1);

    // random mix: mostly well-formed dates, some clamped fields, table rewrites
    for (k = 0; k < 1040; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99);
        m = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        d = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31);
        put_date(y, m, d);
      end else if ($urandom_range(0, 4) < 3) begin
        put_write($urandom_range(FIRST_ROW_BYTE, LAST_ROW_BYTE), $urandom_range(0, 255));
      end else begin
        put_write($urandom_range(0, TABLE_BYTES - 1), $urandom_range(0, 255));
      end
    end
    total_reqs = req_queue.size();

    // hold synchronous reset, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_cnt < total_reqs) @(posedge clk);
    while (lunar_dates_due.size() != 0) @(posedge clk);
    // allow for a stray late result
    repeat (40) @(posedge clk);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
